FILE: rtl/plc_pkg.sv
// Shared widths, types and state encodings for the polyline length accumulator.
package plc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int TOTAL_BITS = 40;
    localparam int SEG_BITS   = 25;

    localparam int SQ_BITS    = 2 * COORD_BITS + 1;
    localparam int RAD_BITS   = SQ_BITS + 2 * FRAC_BITS;
    localparam int ROOT_BITS  = (RAD_BITS + 1) / 2;
    localparam int RADP_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS   = ROOT_BITS + 2;
    localparam int CNT_BITS   = $clog2(ROOT_BITS + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS-1:0]        t_diff;
    typedef logic [SQ_BITS-1:0]           t_sq;
    typedef logic [ROOT_BITS-1:0]         t_root;
    typedef logic [SEG_BITS-1:0]          t_seg;
    typedef logic [TOTAL_BITS-1:0]        t_total;

    localparam t_total TOTAL_MAX = '1;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_X,
        SQ_Y
    } t_sq_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIST,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic  done;
        t_root root;
    } t_root_stat;

endpackage

FILE: rtl/plc_in_if.sv
// Point input channel: valid/ready handshake with kind and coordinates.
interface plc_in_if;
    import plc_pkg::*;

    logic   valid;
    logic   ready;
    logic   kind;
    t_coord x;
    t_coord y;

    modport source (output valid, output kind, output x, output y, input ready);
    modport sink   (input valid, input kind, input x, input y, output ready);
endinterface

FILE: rtl/plc_out_if.sv
// Result output channel: valid/ready handshake with segment and running total.
interface plc_out_if;
    import plc_pkg::*;

    logic   valid;
    logic   ready;
    t_seg   segment_length;
    t_total total_length;
    logic   saturated;

    modport source (output valid, output segment_length, output total_length,
                    output saturated, input ready);
    modport sink   (input valid, input segment_length, input total_length,
                    input saturated, output ready);
endinterface

FILE: rtl/plc_sqdist.sv
// Squared distance unit: absolute differences, then one shared multiplier for the X and Y squares.
module plc_sqdist (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  plc_pkg::t_coord i_x,
    input  plc_pkg::t_coord i_y,
    input  plc_pkg::t_coord i_px,
    input  plc_pkg::t_coord i_py,
    output logic            o_done,
    output plc_pkg::t_sq    o_sq
);
    import plc_pkg::*;

    t_sq_state r_state, n_state;
    t_diff     r_dx, r_dy;
    t_sq       r_sq, n_sq;
    logic      r_done, n_done;

    logic signed [COORD_BITS:0] w_ex, w_ey;
    t_diff                      w_op;
    logic [2*COORD_BITS-1:0]    w_prod;

    assign w_ex   = (COORD_BITS+1)'(i_x) - (COORD_BITS+1)'(i_px);
    assign w_ey   = (COORD_BITS+1)'(i_y) - (COORD_BITS+1)'(i_py);
    assign w_op   = (r_state == SQ_X) ? r_dx : r_dy;
    assign w_prod = w_op * w_op;

    always_comb begin
        n_state = r_state;
        n_sq    = r_sq;
        n_done  = 1'b0;
        case (r_state)
            SQ_IDLE: begin
                if (i_load) begin
                    n_state = SQ_X;
                end
            end
            SQ_X: begin
                n_sq    = SQ_BITS'(w_prod);
                n_state = SQ_Y;
            end
            SQ_Y: begin
                n_sq    = r_sq + SQ_BITS'(w_prod);
                n_done  = 1'b1;
                n_state = SQ_IDLE;
            end
            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dx <= w_ex[COORD_BITS] ? COORD_BITS'(-w_ex) : COORD_BITS'(w_ex);
            r_dy <= w_ey[COORD_BITS] ? COORD_BITS'(-w_ey) : COORD_BITS'(w_ey);
        end
        r_sq <= n_sq;
    end

    assign o_done = r_done;
    assign o_sq   = r_sq;
endmodule

FILE: rtl/plc_sqrt.sv
// Digit-serial integer square root: two radicand bits in, one root bit out per cycle.
module plc_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  plc_pkg::t_sq        i_sq,
    output plc_pkg::t_root_stat o_stat
);
    import plc_pkg::*;

    logic [RADP_BITS-1:0] r_rad;
    logic [REM_BITS-1:0]  r_rem;
    t_root                r_root;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_done;

    logic [REM_BITS-1:0]  w_rem2, w_trial;
    logic                 w_ge;

    assign w_rem2  = {r_rem[REM_BITS-3:0], r_rad[RADP_BITS-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_cnt <= CNT_BITS'(ROOT_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RADP_BITS'(i_sq) << (2 * FRAC_BITS);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {r_root[ROOT_BITS-2:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.root = r_root;
endmodule

FILE: rtl/polyline_length_accumulator.sv
// Polyline length accumulator top level: control, saturating total and result register.
// A start item skips the square root; a next item waits for it in the distance state.
// Items are taken one at a time: a next item holds off the input until the 25-step
// bit-serial square root finishes. A new item is taken while a finished result waits.
// Reset: i_rst_n synchronous, active low; clears the stored point and total to zero
// and empties the result register.
module polyline_length_accumulator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plc_in_if.sink    i_pt,
    plc_out_if.source o_res
);
    import plc_pkg::*;

    t_state     r_state, n_state;
    logic       r_kind;
    t_coord     r_px, r_py;
    t_total     r_total, n_total;
    logic       r_out_valid;
    t_seg       r_out_seg;
    t_total     r_out_total;
    logic       r_out_sat;

    logic       w_accept;
    logic       w_out_write;
    logic       w_sq_done;
    t_sq        w_sq;
    t_root_stat w_root;
    t_total     w_seg_ext;

    assign w_accept = i_pt.valid && i_pt.ready;

    plc_sqdist u_sqdist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && i_pt.kind),
        .i_x     (i_pt.x),
        .i_y     (i_pt.y),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_done  (w_sq_done),
        .o_sq    (w_sq)
    );

    plc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_done),
        .i_sq    (w_sq),
        .o_stat  (w_root)
    );

    assign w_seg_ext = r_kind ? TOTAL_BITS'(w_root.root) : '0;

    always_comb begin
        n_state     = r_state;
        w_out_write = 1'b0;
        if (!r_kind) begin
            n_total = '0;
        end else if (w_seg_ext > (TOTAL_MAX - r_total)) begin
            n_total = TOTAL_MAX;
        end else begin
            n_total = r_total + w_seg_ext;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_pt.kind ? ST_DIST : ST_ACC;
                end
            end
            ST_DIST: begin
                if (w_root.done) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!r_out_valid || o_res.ready) begin
                    w_out_write = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_px        <= '0;
            r_py        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_px <= i_pt.x;
                r_py <= i_pt.y;
            end
            if (w_out_write) begin
                r_total     <= n_total;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_pt.kind;
        end
        if (w_out_write) begin
            r_out_seg   <= SEG_BITS'(w_seg_ext);
            r_out_total <= n_total;
            r_out_sat   <= (n_total == TOTAL_MAX);
        end
    end

    assign i_pt.ready           = (r_state == ST_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.segment_length = r_out_seg;
    assign o_res.total_length   = r_out_total;
    assign o_res.saturated      = r_out_sat;

    a_root_in_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root.done |-> (r_state == ST_DIST))
        else $error("root finished outside distance wait");

    a_start_skips_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_pt.kind) |=> (r_state == ST_ACC))
        else $error("start item did not go straight to accumulate");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_write && !r_kind) |=> (r_out_seg == '0 && r_out_total == '0 && r_total == '0))
        else $error("start item did not clear segment and total");

    a_total_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_write && r_kind) |=> (r_total >= $past(r_total)))
        else $error("running total decreased on a next item");
endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the polyline length accumulator: directed, diagonal and random.
module tb_top;
    import plc_pkg::*;

    localparam logic  KIND_START  = 1'b0;
    localparam logic  KIND_NEXT   = 1'b1;
    localparam t_coord C_MIN      = 16'sh8000;
    localparam t_coord C_MAX      = 16'sh7FFF;
    localparam int    RANDOM_PTS  = 620;
    localparam int    ZIGZAG_PTS  = 8;
    localparam int    HOLD_CYCLES = 150;
    localparam int    DRAIN_WAIT  = 40;
    localparam int    MAX_REPORTS = 40;
    localparam longint CYCLE_LIMIT = 6_000_000;

    typedef struct packed {
        t_seg   seg;
        t_total total;
        logic   sat;
    } path_result_t;

    typedef struct packed {
        logic         kind;
        t_coord       x;
        t_coord       y;
        logic         typed;
        path_result_t res;
    } point_row_t;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    longint cycle_count = 0;
    int     fail_count = 0;
    int     send_calm = 0;
    int     recv_calm = 0;
    bit     full_rate = 1'b0;
    bit     hold_off_req = 1'b0;

    t_coord path_prev_x = '0;
    t_coord path_prev_y = '0;
    t_total path_sum = '0;
    path_result_t expected_lengths[$];

    plc_in_if  pt_if ();
    plc_out_if res_if ();

    polyline_length_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_if),
        .o_res   (res_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] floor_sqrt(logic [63:0] radicand);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = radicand;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic path_result_t advance_path(logic kind, t_coord x, t_coord y);
        longint      dx;
        longint      dy;
        logic [63:0] seg;
        logic [63:0] headroom;
        path_result_t r;
        seg = '0;
        if (kind == KIND_START) begin
            path_sum = '0;
        end else begin
            dx = longint'(x) - longint'(path_prev_x);
            dy = longint'(y) - longint'(path_prev_y);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            seg = floor_sqrt(64'(dx * dx + dy * dy) << (2 * FRAC_BITS));
            headroom = 64'(TOTAL_MAX) - 64'(path_sum);
            if (seg > headroom)
                path_sum = TOTAL_MAX;
            else
                path_sum = t_total'(64'(path_sum) + seg);
        end
        path_prev_x = x;
        path_prev_y = y;
        r.seg   = t_seg'(seg);
        r.total = path_sum;
        r.sat   = (path_sum == TOTAL_MAX);
        return r;
    endfunction

    function automatic int draw_gap(inout int calm);
        if (full_rate)
            return 0;
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm = $urandom_range(10, 30);
        return $urandom_range(0, 5);
    endfunction

    task automatic send_point(input logic kind, input t_coord x, input t_coord y,
                              input logic typed, input path_result_t typed_res);
        int           gap;
        path_result_t predicted;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            pt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.kind  <= kind;
        pt_if.x     <= x;
        pt_if.y     <= y;
        @(posedge i_clk);
        while (!pt_if.ready) @(posedge i_clk);
        predicted = advance_path(kind, x, y);
        expected_lengths.push_back(typed ? typed_res : predicted);
    endtask

    task automatic report_field(input string name, input longint unsigned exp_v,
                                input longint unsigned act_v);
        if (exp_v != act_v) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        path_result_t exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_lengths.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result expected none actual seg=%0d total=%0d sat=%0d",
                             $time, res_if.segment_length, res_if.total_length,
                             res_if.saturated);
            end else begin
                exp_r = expected_lengths.pop_front();
                report_field("segment_length", exp_r.seg, res_if.segment_length);
                report_field("total_length", exp_r.total, res_if.total_length);
                report_field("saturated", exp_r.sat, res_if.saturated);
            end
        end
    end

    initial begin
        int gap;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                gap = HOLD_CYCLES;
            end else begin
                gap = draw_gap(recv_calm);
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    initial begin
        point_row_t   directed_rows [20];
        path_result_t no_res;
        t_coord       last_x;
        t_coord       last_y;
        t_coord       nx;
        t_coord       ny;
        logic         kind;
        int           extra;
        directed_rows = '{
            '{KIND_NEXT,  16'sd3,      16'sd4,      1'b1, '{25'd1280, 40'd1280, 1'b0}},
            '{KIND_NEXT,  16'sd0,      16'sd0,      1'b1, '{25'd1280, 40'd2560, 1'b0}},
            '{KIND_START, C_MIN,       C_MIN,       1'b1, '{25'd0, 40'd0, 1'b0}},
            '{KIND_NEXT,  C_MAX,       C_MAX,       1'b0, '0},
            '{KIND_NEXT,  C_MIN,       C_MAX,       1'b0, '0},
            '{KIND_NEXT,  C_MIN,       C_MIN,       1'b0, '0},
            '{KIND_NEXT,  C_MAX,       C_MIN,       1'b0, '0},
            '{KIND_START, C_MAX,       C_MIN,       1'b1, '{25'd0, 40'd0, 1'b0}},
            '{KIND_NEXT,  C_MAX,       C_MIN,       1'b1, '{25'd0, 40'd0, 1'b0}},
            '{KIND_NEXT,  16'sh5555,   16'shAAAA,   1'b0, '0},
            '{KIND_NEXT,  16'shAAAA,   16'sh5555,   1'b0, '0},
            '{KIND_START, 16'sd0,      16'sd0,      1'b1, '{25'd0, 40'd0, 1'b0}},
            '{KIND_NEXT,  16'sd1,      16'sd1,      1'b0, '0},
            '{KIND_NEXT,  16'sd1,      16'sd0,      1'b0, '0},
            '{KIND_NEXT,  -16'sd1,     16'sd0,      1'b0, '0},
            '{KIND_START, -16'sd1,     -16'sd1,     1'b1, '{25'd0, 40'd0, 1'b0}},
            '{KIND_NEXT,  16'sd0,      -16'sd1,     1'b1, '{25'd256, 40'd256, 1'b0}},
            '{KIND_NEXT,  16'sd0,      -16'sd1,     1'b1, '{25'd0, 40'd256, 1'b0}},
            '{KIND_NEXT,  16'sd1,      C_MAX,       1'b0, '0},
            '{KIND_START, C_MIN,       16'sd0,      1'b1, '{25'd0, 40'd0, 1'b0}}
        };
        no_res = '0;
        i_rst_n     <= 1'b0;
        pt_if.valid <= 1'b0;
        pt_if.kind  <= KIND_START;
        pt_if.x     <= '0;
        pt_if.y     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_point(directed_rows[i].kind, directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].typed, directed_rows[i].res);

        // zigzag across the full diagonal back to back for the longest segments
        full_rate = 1'b1;
        send_point(KIND_START, C_MIN, C_MIN, 1'b0, no_res);
        for (extra = 0; extra < ZIGZAG_PTS; extra++) begin
            if (path_prev_x == C_MIN)
                send_point(KIND_NEXT, C_MAX, C_MAX, 1'b0, no_res);
            else
                send_point(KIND_NEXT, C_MIN, C_MIN, 1'b0, no_res);
        end
        send_point(KIND_START, C_MAX, C_MAX, 1'b0, no_res);
        send_point(KIND_NEXT, C_MIN, C_MAX, 1'b0, no_res);
        full_rate = 1'b0;

        last_x = path_prev_x;
        last_y = path_prev_y;
        for (int n = 0; n < RANDOM_PTS; n++) begin
            if (n == 100 || n == 400)
                hold_off_req = 1'b1;
            kind = ($urandom_range(0, 9) == 0) ? KIND_START : KIND_NEXT;
            case ($urandom_range(0, 7))
                0, 1, 2, 3: begin
                    nx = t_coord'($urandom_range(0, 65535));
                    ny = t_coord'($urandom_range(0, 65535));
                end
                4, 5, 6: begin
                    nx = t_coord'(int'(last_x) + int'($urandom_range(0, 128)) - 64);
                    ny = t_coord'(int'(last_y) + int'($urandom_range(0, 128)) - 64);
                end
                default: begin
                    nx = ($urandom_range(0, 1) != 0) ? C_MIN : C_MAX;
                    ny = ($urandom_range(0, 1) != 0) ? C_MIN : C_MAX;
                end
            endcase
            send_point(kind, nx, ny, 1'b0, no_res);
            last_x = nx;
            last_y = ny;
        end
        pt_if.valid <= 1'b0;

        while (expected_lengths.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
